// File: design/ccbf_pkg.sv
package ccbf_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [31:0] HEADER_BYTES    = 32'd12;
  localparam logic [31:0] HEADER_MAGIC    = 32'h6e53_4345;
  localparam logic [31:0] ORDER_WORD      = 32'hec51_1235;
  localparam logic [31:0] VERSION_WORD    = 32'h0000_0001;
  localparam logic [31:0] TERMINATOR_WORD = 32'hdead_beef;

  typedef enum logic [3:0] {
    ST_FOUND       = 4'd0,
    ST_NOT_FOUND   = 4'd1,
    ST_SHORT       = 4'd2,
    ST_BAD_MAGIC   = 4'd3,
    ST_BAD_ORDER   = 4'd4,
    ST_BAD_VERSION = 4'd5,
    ST_TRUNCATED   = 4'd6,
    ST_BAD_TERM    = 4'd7,
    ST_DUPLICATE   = 4'd8
  } status_t;

  // one classified byte on its way to the parser
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_last;
    logic [31:0] offset;
    logic        short_file;
  } entry_t;

endpackage

// File: design/ccbf_ifs.sv
interface ccbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface ccbf_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] payload_offset;
  logic [31:0] payload_size;

  modport source (output valid, output status, output payload_offset, output payload_size,
                  input ready);
  modport sink (input valid, input status, input payload_offset, input payload_size,
                output ready);
endinterface

interface ccbf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_magic;

  modport source (output valid, output target_magic, input ready);
  modport sink (input valid, input target_magic, output ready);
endinterface

// File: design/chunk_container_block_finder_unit.sv
// Container block finder.
// bytes  : one file byte per item (data_byte, is_last); is_last marks the
//          end of a file, and the next item starts a new one.
// cfg    : target_magic write channel, always ready; write only while idle.
// result : one item per file (status, payload_offset, payload_size), given
//          after the last byte.
// Throughput is one byte per cycle while bytes.ready is high. A front
// stage counts byte positions and tags short files, a queue of
// QUEUE_DEPTH items decouples it from the parser, which takes one byte a
// cycle from the queue unless held as below. The last byte is written
// into the queue first; the parser then pops it and loads the result
// register.
// When a result waits on a stalled receiver, the parser holds at the next
// last byte while later bytes fill the queue; once it is full, bytes.ready
// drops.
// Reset clears the parse state, the queue, the result register and
// target_magic (to 0); no clearing pass is needed.
module chunk_container_block_finder_unit import ccbf_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  ccbf_in_if.sink     bytes,
  ccbf_cfg_if.sink    cfg,
  ccbf_out_if.source  result
);

  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   q_valid;
  entry_t q_entry;

  ccbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ccbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  ccbf_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

// File: design/ccbf_front.sv
module ccbf_front import ccbf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  ccbf_in_if.sink bytes,
  input  logic   q_full,
  output logic   push,
  output entry_t push_entry
);

  logic [31:0] byte_position;

  always_comb begin
    bytes.ready           = !q_full;
    push                  = bytes.valid && !q_full;
    push_entry.data_byte  = bytes.data_byte;
    push_entry.is_last    = bytes.is_last;
    push_entry.offset     = byte_position;
    // fewer than a header's worth once this item is counted
    push_entry.short_file = byte_position < (HEADER_BYTES - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (push) begin
      if (bytes.is_last) begin
        byte_position <= '0;
      end else if (byte_position != '1) begin
        byte_position <= byte_position + 32'd1;
      end
    end
  end

endmodule

// File: design/ccbf_queue.sv
module ccbf_queue import ccbf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t q_entry
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  entry_t              slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full    = count == FULL_CNT;
  assign q_valid = count != '0;
  assign q_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// File: design/ccbf_back.sv
module ccbf_back import ccbf_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        pop,
  ccbf_cfg_if.sink    cfg,
  ccbf_out_if.source  result
);

  localparam logic [33:0] LIMIT = 34'd1 << OFFSET_BITS;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_ORDER   = 3'd1,
    PH_VERSION = 3'd2,
    PH_TAG     = 3'd3,
    PH_SIZE    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_TERM    = 3'd6,
    PH_FULL    = 3'd7
  } phase_t;

  logic [31:0]            target_magic;
  phase_t                 phase,          phase_next;
  logic [31:0]            shift,          shift_next;
  logic [1:0]             cnt,            cnt_next;
  logic [31:0]            remaining,      remaining_next;
  logic                   tag_match,      tag_match_next;
  logic                   found,          found_next;
  logic [OFFSET_BITS-1:0] found_offset,   found_offset_next;
  logic [31:0]            found_size,     found_size_next;
  status_t                err,            err_next;   // ST_FOUND: no error yet
  status_t                status_next;

  logic                   out_valid;
  status_t                out_status;
  logic [31:0]            out_offset;
  logic [31:0]            out_size;

  logic [31:0]            word;
  logic [33:0]            block_end;

  assign pop       = q_valid && (!q_entry.is_last || !out_valid || result.ready);
  assign cfg.ready = 1'b1;

  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.payload_offset = out_offset;
  assign result.payload_size   = out_size;

  always_comb begin
    phase_next        = phase;
    shift_next        = shift;
    cnt_next          = cnt;
    remaining_next    = remaining;
    tag_match_next    = tag_match;
    found_next        = found;
    found_offset_next = found_offset;
    found_size_next   = found_size;
    err_next          = err;

    word      = shift | (32'(q_entry.data_byte) << {cnt, 3'b000});
    block_end = 34'(q_entry.offset) + 34'(word) + 34'd5;

    if (err == ST_FOUND) begin
      unique case (phase)
        PH_FULL: begin
          err_next = ST_TRUNCATED;
        end
        PH_PAYLOAD: begin
          remaining_next = remaining - 32'd1;
          if (remaining == 32'd1) begin
            phase_next = PH_TERM;
          end
        end
        default: begin
          if (cnt != 2'd3) begin
            shift_next = word;
            cnt_next   = cnt + 2'd1;
          end else begin
            shift_next = '0;
            cnt_next   = '0;
            unique case (phase)
              PH_MAGIC: begin
                if (word != HEADER_MAGIC) err_next = ST_BAD_MAGIC;
                else phase_next = PH_ORDER;
              end
              PH_ORDER: begin
                if (word != ORDER_WORD) err_next = ST_BAD_ORDER;
                else phase_next = PH_VERSION;
              end
              PH_VERSION: begin
                if (word != VERSION_WORD) err_next = ST_BAD_VERSION;
                else phase_next = PH_TAG;
              end
              PH_TAG: begin
                tag_match_next = word == target_magic;
                phase_next     = PH_SIZE;
              end
              PH_SIZE: begin
                if (block_end > LIMIT) begin
                  err_next = ST_TRUNCATED;
                end else begin
                  remaining_next = word;
                  if (tag_match && !found) begin
                    found_offset_next = q_entry.offset[OFFSET_BITS-1:0]
                                        + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
                    found_size_next   = word;
                  end
                  phase_next = (word != '0) ? PH_PAYLOAD : PH_TERM;
                end
              end
              default: begin
                if (word != TERMINATOR_WORD) begin
                  err_next = ST_BAD_TERM;
                end else if (tag_match && found) begin
                  err_next = ST_DUPLICATE;
                end else begin
                  if (tag_match) found_next = 1'b1;
                  phase_next = (34'(q_entry.offset) == LIMIT - 34'd1) ? PH_FULL : PH_TAG;
                end
              end
            endcase
          end
        end
      endcase
    end

    if (q_entry.short_file) begin
      status_next = ST_SHORT;
    end else if (err_next != ST_FOUND) begin
      status_next = err_next;
    end else if (!((phase_next == PH_TAG && cnt_next == 2'd0) || phase_next == PH_FULL)) begin
      status_next = ST_TRUNCATED;
    end else begin
      status_next = found_next ? ST_FOUND : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_magic <= '0;
      phase        <= PH_MAGIC;
      shift        <= '0;
      cnt          <= '0;
      remaining    <= '0;
      tag_match    <= 1'b0;
      found        <= 1'b0;
      found_offset <= '0;
      found_size   <= '0;
      err          <= ST_FOUND;
      out_valid    <= 1'b0;
      out_status   <= ST_FOUND;
      out_offset   <= '0;
      out_size     <= '0;
    end else begin
      if (cfg.valid) begin
        target_magic <= cfg.target_magic;
      end
      if (pop && q_entry.is_last) begin
        out_valid    <= 1'b1;
        out_status   <= status_next;
        out_offset   <= (status_next == ST_FOUND) ? 32'(found_offset_next) : '0;
        out_size     <= (status_next == ST_FOUND) ? found_size_next : '0;
        phase        <= PH_MAGIC;
        shift        <= '0;
        cnt          <= '0;
        remaining    <= '0;
        tag_match    <= 1'b0;
        found        <= 1'b0;
        found_offset <= '0;
        found_size   <= '0;
        err          <= ST_FOUND;
      end else begin
        if (result.ready) begin
          out_valid <= 1'b0;
        end
        if (pop) begin
          phase        <= phase_next;
          shift        <= shift_next;
          cnt          <= cnt_next;
          remaining    <= remaining_next;
          tag_match    <= tag_match_next;
          found        <= found_next;
          found_offset <= found_offset_next;
          found_size   <= found_size_next;
          err          <= err_next;
        end
      end
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    pop && q_entry.is_last |=> out_valid)
    else $error("last item popped without a result");
  a_miss_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_FOUND |-> out_offset == '0 && out_size == '0)
    else $error("offset or size set on a miss");
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> remaining != '0)
    else $error("payload phase with nothing left");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ccbf_pkg::*;

  localparam int          OFF_BITS   = OFFSET_BITS_DEFAULT;
  localparam logic [63:0] SPAN       = 64'd1 << OFF_BITS;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          N_DIR      = 19;
  localparam int          N_PHASES   = 6;

  typedef enum logic [2:0] {
    WALK_MAGIC, WALK_ORDER, WALK_VERSION, WALK_TAG,
    WALK_SIZE, WALK_PAYLOAD, WALK_TERM, WALK_FULL
  } walk_t;

  typedef enum int {
    K_SHORT, K_HDR_ONLY, K_BAD_MAGIC, K_BAD_ORDER, K_BAD_VERSION, K_MAGIC_AND_ORDER,
    K_ONE_BLOCK, K_TWO_BLOCKS, K_END_IN_PAYLOAD, K_END_IN_WORD, K_BAD_TERM,
    K_DUPLICATE, K_BIG_SIZE, K_TAIL_BYTES
  } file_kind_t;

  typedef struct {
    status_t     status;
    logic [31:0] off;
    logic [31:0] len;
  } block_report_t;

  typedef struct {
    bit            typed;
    block_report_t rep;
  } file_note_t;

  typedef struct {
    file_kind_t  kind;
    logic [31:0] arg;
    bit          typed;
    status_t     status;
    logic [31:0] off;
    logic [31:0] len;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    '{K_SHORT,           32'd1,          1'b1, ST_SHORT,       32'd0,  32'd0},
    '{K_SHORT,           32'd4,          1'b1, ST_SHORT,       32'd0,  32'd0},
    '{K_SHORT,           32'd11,         1'b1, ST_SHORT,       32'd0,  32'd0},
    '{K_HDR_ONLY,        32'd0,          1'b1, ST_NOT_FOUND,   32'd0,  32'd0},
    '{K_BAD_MAGIC,       32'd0,          1'b1, ST_BAD_MAGIC,   32'd0,  32'd0},
    '{K_BAD_ORDER,       32'd0,          1'b1, ST_BAD_ORDER,   32'd0,  32'd0},
    '{K_BAD_VERSION,     32'd0,          1'b1, ST_BAD_VERSION, 32'd0,  32'd0},
    '{K_MAGIC_AND_ORDER, 32'd0,          1'b1, ST_BAD_MAGIC,   32'd0,  32'd0},
    '{K_ONE_BLOCK,       32'd3,          1'b1, ST_FOUND,       32'd20, 32'd3},
    '{K_ONE_BLOCK,       32'd0,          1'b1, ST_FOUND,       32'd20, 32'd0},
    '{K_TWO_BLOCKS,      32'd2,          1'b0, ST_FOUND,       32'd0,  32'd0},
    '{K_END_IN_PAYLOAD,  32'd0,          1'b1, ST_TRUNCATED,   32'd0,  32'd0},
    '{K_END_IN_WORD,     32'd0,          1'b1, ST_TRUNCATED,   32'd0,  32'd0},
    '{K_BAD_TERM,        32'd0,          1'b1, ST_BAD_TERM,    32'd0,  32'd0},
    '{K_DUPLICATE,       32'd0,          1'b1, ST_DUPLICATE,   32'd0,  32'd0},
    '{K_BIG_SIZE,        32'hffff_ffff,  1'b1, ST_TRUNCATED,   32'd0,  32'd0},
    '{K_BIG_SIZE,        32'hffff_ffe9,  1'b0, ST_FOUND,       32'd0,  32'd0},
    '{K_BIG_SIZE,        32'hffff_ffe8,  1'b0, ST_FOUND,       32'd0,  32'd0},
    '{K_TAIL_BYTES,      32'd2,          1'b0, ST_FOUND,       32'd0,  32'd0}
  };

  logic clk = 1'b0;
  logic rst;

  ccbf_in_if  byte_ch ();
  ccbf_cfg_if cfg_ch ();
  ccbf_out_if rep_ch ();

  chunk_container_block_finder_unit dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .cfg    (cfg_ch),
    .result (rep_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // walker state, tracks the block
  logic [31:0] tgt_model;
  logic [31:0] w_pos;
  walk_t       w_phase;
  logic [31:0] w_acc;
  logic [1:0]  w_cnt;
  logic [31:0] w_left;
  logic        w_match;
  logic        w_have;
  logic [31:0] w_off;
  logic [31:0] w_len;
  logic        w_err_set;
  status_t     w_err;

  block_report_t report_q [$];
  file_note_t    note_q [$];
  logic [7:0]    file_bytes [$];

  logic [31:0] tgt_sel;
  int tx_gaps;
  int burst_left;
  int files_sent;
  int bytes_sent;
  int results_seen;
  int mismatches;
  int settings;
  int status_seen [16];
  int cycles;
  int rx_cycle;
  int rx_mode;
  int stall_left;

  block_report_t pred;
  block_report_t want;
  file_note_t    note;

  function automatic void clear_walk();
    w_pos     = '0;
    w_phase   = WALK_MAGIC;
    w_acc     = '0;
    w_cnt     = '0;
    w_left    = '0;
    w_match   = 1'b0;
    w_have    = 1'b0;
    w_off     = '0;
    w_len     = '0;
    w_err_set = 1'b0;
    w_err     = ST_FOUND;
  endfunction

  function automatic void flag_error(status_t s);
    w_err_set = 1'b1;
    w_err     = s;
  endfunction

  function automatic void finish_word(logic [31:0] w, logic [31:0] off);
    case (w_phase)
      WALK_MAGIC: begin
        if (w != HEADER_MAGIC) flag_error(ST_BAD_MAGIC);
        else w_phase = WALK_ORDER;
      end
      WALK_ORDER: begin
        if (w != ORDER_WORD) flag_error(ST_BAD_ORDER);
        else w_phase = WALK_VERSION;
      end
      WALK_VERSION: begin
        if (w != VERSION_WORD) flag_error(ST_BAD_VERSION);
        else w_phase = WALK_TAG;
      end
      WALK_TAG: begin
        w_match = (w == tgt_model);
        w_phase = WALK_SIZE;
      end
      WALK_SIZE: begin
        if ({32'd0, off} + 64'd1 + {32'd0, w} + 64'd4 > SPAN) begin
          flag_error(ST_TRUNCATED);
        end else begin
          w_left = w;
          if (w_match && !w_have) begin
            w_off = off + 32'd1;
            w_len = w;
          end
          w_phase = (w != 32'd0) ? WALK_PAYLOAD : WALK_TERM;
        end
      end
      default: begin
        if (w != TERMINATOR_WORD) flag_error(ST_BAD_TERM);
        else if (w_match && w_have) flag_error(ST_DUPLICATE);
        else begin
          if (w_match) w_have = 1'b1;
          w_phase = ({32'd0, off} == SPAN - 64'd1) ? WALK_FULL : WALK_TAG;
        end
      end
    endcase
  endfunction

  function automatic void take_byte(logic [7:0] b, logic [31:0] off);
    logic [31:0] w;
    if (w_phase == WALK_FULL) begin
      flag_error(ST_TRUNCATED);
    end else if (w_phase == WALK_PAYLOAD) begin
      w_left = w_left - 32'd1;
      if (w_left == 32'd0) w_phase = WALK_TERM;
    end else begin
      w_acc = w_acc | (32'(b) << (8 * w_cnt));
      if (w_cnt == 2'd3) begin
        w     = w_acc;
        w_acc = '0;
        w_cnt = '0;
        finish_word(w, off);
      end else begin
        w_cnt = w_cnt + 2'd1;
      end
    end
  endfunction

  function automatic bit walk_byte(input logic [7:0] b, input logic last,
                                   output block_report_t r);
    status_t s;
    if (!w_err_set) take_byte(b, w_pos);
    if (w_pos != 32'hffff_ffff) w_pos = w_pos + 32'd1;
    if (!last) return 1'b0;
    if (w_pos < HEADER_BYTES) s = ST_SHORT;
    else if (w_err_set) s = w_err;
    else if (!((w_phase == WALK_TAG && w_cnt == 2'd0) || w_phase == WALK_FULL))
      s = ST_TRUNCATED;
    else s = w_have ? ST_FOUND : ST_NOT_FOUND;
    r.status = s;
    r.off    = (s == ST_FOUND) ? w_off : 32'd0;
    r.len    = (s == ST_FOUND) ? w_len : 32'd0;
    clear_walk();
    return 1'b1;
  endfunction

  function automatic void note_mismatch(string what, block_report_t e);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: exp st=%0d off=%h len=%h  got st=%0d off=%h len=%h", $realtime,
               what, e.status, e.off, e.len, rep_ch.status, rep_ch.payload_offset,
               rep_ch.payload_size);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tgt_model = '0;
      clear_walk();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) tgt_model = cfg_ch.target_magic;
      if (byte_ch.valid && byte_ch.ready) begin
        if (walk_byte(byte_ch.data_byte, byte_ch.is_last, pred)) begin
          note.typed = 1'b0;
          if (note_q.size() != 0) note = note_q.pop_front();
          report_q.push_back(note.typed ? note.rep : pred);
        end
      end
      if (rep_ch.valid && rep_ch.ready) begin
        results_seen++;
        status_seen[rep_ch.status]++;
        if (report_q.size() == 0) begin
          want = '{ST_FOUND, 32'd0, 32'd0};
          note_mismatch("unexpected item", want);
        end else begin
          want = report_q.pop_front();
          if (rep_ch.status !== want.status || rep_ch.payload_offset !== want.off ||
              rep_ch.payload_size !== want.len)
            note_mismatch("mismatch", want);
        end
      end
    end
  end

  // result-side stalls: a random mode holds ready high, drives it at random, or drops it in bursts
  always @(posedge clk) begin
    if (rst) begin
      rep_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (stall_left != 0) begin
        stall_left--;
        rep_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: rep_ch.ready <= 1'b1;
          1: rep_ch.ready <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 9) == 0) begin
              stall_left = $urandom_range(1, 12);
              rep_ch.ready <= 1'b0;
            end else begin
              rep_ch.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               files_sent - results_seen);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void put_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) file_bytes.push_back(w[8*k +: 8]);
  endfunction

  function automatic void put_header();
    put_word(HEADER_MAGIC);
    put_word(ORDER_WORD);
    put_word(VERSION_WORD);
  endfunction

  function automatic void put_block(logic [31:0] tag, int unsigned len, logic [31:0] term);
    put_word(tag);
    put_word(len);
    repeat (len) file_bytes.push_back(8'($urandom));
    put_word(term);
  endfunction

  function automatic void build_directed(dir_row_t r);
    file_bytes.delete();
    case (r.kind)
      K_SHORT: begin
        put_header();
        if (r.arg < 8) foreach (file_bytes[j]) file_bytes[j] = ~file_bytes[j];
        file_bytes = file_bytes[0:r.arg-1];
      end
      K_HDR_ONLY: put_header();
      K_BAD_MAGIC: begin
        put_word(HEADER_MAGIC ^ 32'h0100_0000);
        put_word(ORDER_WORD);
        put_word(VERSION_WORD);
      end
      K_BAD_ORDER: begin
        put_word(HEADER_MAGIC);
        put_word(~ORDER_WORD);
        put_word(VERSION_WORD);
      end
      K_BAD_VERSION: begin
        put_word(HEADER_MAGIC);
        put_word(ORDER_WORD);
        put_word(32'd2);
        put_block(tgt_sel, 1, TERMINATOR_WORD);
      end
      K_MAGIC_AND_ORDER: begin
        put_word(32'd0);
        put_word(32'd0);
        put_word(VERSION_WORD);
      end
      K_ONE_BLOCK: begin
        put_header();
        put_block(tgt_sel, r.arg, TERMINATOR_WORD);
      end
      K_TWO_BLOCKS: begin
        put_header();
        put_block(~tgt_sel, r.arg, TERMINATOR_WORD);
        put_block(tgt_sel, 1, TERMINATOR_WORD);
      end
      K_END_IN_PAYLOAD: begin
        put_header();
        put_word(tgt_sel);
        put_word(32'd5);
        repeat (2) file_bytes.push_back(8'($urandom));
      end
      K_END_IN_WORD: begin
        put_header();
        repeat (2) file_bytes.push_back(8'($urandom));
      end
      K_BAD_TERM: begin
        put_header();
        put_block(tgt_sel, 2, TERMINATOR_WORD ^ 32'd1);
      end
      K_DUPLICATE: begin
        put_header();
        put_block(tgt_sel, 1, TERMINATOR_WORD);
        put_block(tgt_sel, 2, TERMINATOR_WORD);
      end
      K_BIG_SIZE: begin
        put_header();
        put_word(tgt_sel);
        put_word(r.arg);
        repeat (3) file_bytes.push_back(8'($urandom));
      end
      default: begin
        put_header();
        put_block(tgt_sel, 2, TERMINATOR_WORD);
        repeat (r.arg) file_bytes.push_back(8'($urandom));
      end
    endcase
  endfunction

  // mostly well-formed containers with random content; some broken on purpose
  function automatic void make_random_file();
    int r;
    int nblk;
    int hits;
    int len;
    int pick;
    logic [31:0] tag;
    file_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 6) begin
      repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom));
      return;
    end
    put_header();
    nblk = $urandom_range(0, 4);
    hits = 0;
    for (int k = 0; k < nblk; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3 && (hits == 0 || $urandom_range(0, 3) == 0)) begin
        tag = tgt_sel;
        hits++;
      end else if (pick == 3) begin
        tag = tgt_sel ^ (32'd1 << $urandom_range(0, 31));
      end else begin
        tag = $urandom;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      put_block(tag, len, TERMINATOR_WORD);
    end
    if (r < 12) begin
      put_word(($urandom_range(0, 1) != 0) ? tgt_sel : 32'($urandom));
      put_word(32'h8000_0000 | 32'($urandom));
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
    end else if (r < 22) begin
      file_bytes = file_bytes[0:$urandom_range(1, file_bytes.size() - 1) - 1];
    end else if (r < 32) begin
      pick = $urandom_range(0, file_bytes.size() - 1);
      file_bytes[pick] = file_bytes[pick] ^ (8'd1 << $urandom_range(0, 7));
    end else if (r < 37) begin
      repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
    end else if (r < 40) begin
      put_block(tgt_sel, $urandom_range(0, 3), $urandom);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (tx_gaps != 0 && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.is_last   <= last;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_file(input bit typed, input block_report_t rep);
    note_q.push_back('{typed, rep});
    foreach (file_bytes[j]) send_byte(file_bytes[j], j == file_bytes.size() - 1);
    files_sent++;
  endtask

  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    while (results_seen < files_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_target(input logic [31:0] v);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.target_magic <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tgt_sel = v;
    settings++;
  endtask

  initial begin
    int b0;
    int f0;
    logic [31:0] v;
    block_report_t none;
    rst                 = 1'b1;
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = '0;
    byte_ch.is_last     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.target_magic = '0;
    rep_ch.ready        = 1'b0;
    tgt_sel             = '0;
    tx_gaps             = 1;
    settings            = 1;
    none                = '{ST_FOUND, 32'd0, 32'd0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed files, target still at its reset value
    foreach (dir_rows[i]) begin
      build_directed(dir_rows[i]);
      send_file(dir_rows[i].typed,
                '{dir_rows[i].status, dir_rows[i].off, dir_rows[i].len});
    end
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: v = 32'hffff_ffff;
        1: v = 32'h0000_0000;
        3: v = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                8'($urandom_range(65, 90)), 8'($urandom_range(65, 90))};
        5: v = HEADER_MAGIC;
        default: v = $urandom;
      endcase
      write_target(v);
      tx_gaps = (p % 3 != 1);
      b0 = bytes_sent;
      f0 = files_sent;
      while (bytes_sent - b0 < 70 || files_sent - f0 < 2) begin
        make_random_file();
        send_file(1'b0, none);
      end
      wait_idle();
    end

    if (report_q.size() != 0) begin
      mismatches += report_q.size();
      $display("%0d expected items never arrived", report_q.size());
    end
    $display("Run covered %0d files (%0d bytes) over %0d target settings, %0d results.",
             files_sent, bytes_sent, settings, results_seen);
    $display("Status mix: found %0d, not found %0d, errors %0d; mismatches %0d.",
             status_seen[ST_FOUND], status_seen[ST_NOT_FOUND],
             results_seen - status_seen[ST_FOUND] - status_seen[ST_NOT_FOUND], mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ccbf_pkg.sv
design/ccbf_ifs.sv
design/ccbf_front.sv
design/ccbf_queue.sv
design/ccbf_back.sv
design/chunk_container_block_finder_unit.sv
verif/tb_top.sv
